### hw/rtl/cfd_pkg.sv
package cfd_pkg;

  // Depth of the queue between the parser and the result stage.
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned StatusW = 2;

  // Kind of a result item.
  typedef enum logic {
    KindByte = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  // Frame status codes.
  localparam logic [StatusW-1:0] StatusGood     = 2'd0;
  localparam logic [StatusW-1:0] StatusSumError = 2'd1;
  localparam logic [StatusW-1:0] StatusUnknown  = 2'd2;

  // Command codes the link understands.
  localparam logic [WordW-1:0] CmdZero  = 16'h0000;
  localparam logic [WordW-1:0] CmdOne   = 16'h0001;
  localparam logic [WordW-1:0] CmdTwo   = 16'h0002;
  localparam logic [WordW-1:0] CmdThree = 16'h0003;
  localparam logic [WordW-1:0] CmdFive  = 16'h0005;

  // One classified item as the parser hands it to the result stage.
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic [WordW-1:0]  index;
    logic [WordW-1:0]  command;
    logic              sum_bad;
  } item_t;

  function automatic logic is_known_cmd(input logic [WordW-1:0] cmd);
    is_known_cmd = (cmd == CmdZero) || (cmd == CmdOne) || (cmd == CmdTwo) ||
                   (cmd == CmdThree) || (cmd == CmdFive);
  endfunction

endpackage

### hw/rtl/cfd_intf.sv
interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_header;

  modport source (output valid, output frame_header, input ready);
  modport sink (input valid, input frame_header, output ready);
endinterface

interface cfd_res_if;
  logic        valid;
  logic        ready;
  logic [0:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] command;
  logic [1:0]  frame_status;
  logic [0:0]  last;

  modport source (output valid, output result_kind, output payload_byte,
                  output byte_index, output command, output frame_status,
                  output last, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input byte_index, input command, input frame_status,
                input last, output ready);
endinterface

### hw/rtl/checksum_frame_deframer_unit.sv
// Frame deframer for a byte-serial link with an additive 8-bit checksum.
// The rx_i channel carries one received link byte per item. The parser looks
// for the configured 16-bit little-endian header, then reads a command word,
// a payload length and the payload, and closes the frame at the checksum
// byte. Every payload byte leaves on res_o as one item with its command and
// its index; the checksum byte leaves as an end-of-frame item with a status
// (good, checksum mismatch, or unknown command). Header, command and length
// bytes produce no item. The cfg_i channel writes the expected header; it is
// always ready and should only be written while the block is idle.
// Throughput is one byte per cycle while the queue has room. A payload or
// checksum byte is written into the queue when it is accepted and moves from
// there into the output register, which drives its item on res_o.
// At reset the parser hunts for the first header byte, the
// header register is zero and the queue and output register are empty.
// When the receiver holds res_o.ready low, the output register keeps its item
// and the two-entry queue fills; once it is full rx_i.ready drops and stays
// low until the receiver takes an item again.
module checksum_frame_deframer_unit #(
  parameter int unsigned QueueDepth = cfd_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfd_rx_if.sink     rx_i,
  cfd_cfg_if.sink    cfg_i,
  cfd_res_if.source  res_o
);

  logic [cfd_pkg::WordW-1:0] header_q;
  logic                      push;
  logic                      push_ready;
  logic                      pop;
  logic                      pop_valid;
  cfd_pkg::item_t            push_item;
  cfd_pkg::item_t            pop_item;

  // The header register takes a write in any cycle; the parser sees the new
  // value at its next header comparison.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
    end else if (cfg_i.valid) begin
      header_q <= cfg_i.frame_header;
    end
  end

  // Parser: takes each byte while the queue has room and classifies it by frame phase.
  cfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_header_i (header_q),
    .rx_valid_i     (rx_i.valid),
    .rx_byte_i      (rx_i.rx_byte),
    .rx_ready_o     (rx_i.ready),
    .push_ready_i   (push_ready),
    .push_o         (push),
    .item_o         (push_item)
  );

  // Short queue that lets the parser and the result stage stall apart.
  cfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .item_o       (pop_item)
  );

  // Result stage: resolves the frame status and drives the output register.
  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

### hw/rtl/cfd_front.sv
module cfd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cfd_pkg::WordW-1:0]         frame_header_i,
  input  logic                              rx_valid_i,
  input  logic [cfd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              rx_ready_o,
  input  logic                              push_ready_i,
  output logic                              push_o,
  output cfd_pkg::item_t                    item_o
);

  localparam logic [2:0] PhHeadLo = 3'd0;
  localparam logic [2:0] PhHeadHi = 3'd1;
  localparam logic [2:0] PhCmdLo  = 3'd2;
  localparam logic [2:0] PhCmdHi  = 3'd3;
  localparam logic [2:0] PhLenLo  = 3'd4;
  localparam logic [2:0] PhLenHi  = 3'd5;
  localparam logic [2:0] PhData   = 3'd6;
  localparam logic [2:0] PhSum    = 3'd7;

  logic [2:0]                      phase_q, phase_d;
  logic [cfd_pkg::WordW-1:0]       cmd_q, cmd_d;
  logic [cfd_pkg::WordW-1:0]       len_q, len_d;
  logic [cfd_pkg::WordW-1:0]       seen_q, seen_d;
  logic [cfd_pkg::ByteW-1:0]       sum_q, sum_d;
  logic [cfd_pkg::ByteW-1:0]       lo_q, lo_d;
  logic [cfd_pkg::WordW:0]         seen_next;
  logic [cfd_pkg::WordW-1:0]       new_len;
  logic                            accept;

  assign rx_ready_o = push_ready_i;
  assign accept     = rx_valid_i && push_ready_i;
  assign seen_next  = {1'b0, seen_q} + {{cfd_pkg::WordW{1'b0}}, 1'b1};
  assign new_len    = {rx_byte_i, lo_q};

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    seen_d  = seen_q;
    sum_d   = sum_q;
    lo_d    = lo_q;
    push_o  = 1'b0;
    item_o.kind    = cfd_pkg::KindByte;
    item_o.data    = rx_byte_i;
    item_o.index   = seen_q;
    item_o.command = cmd_q;
    item_o.sum_bad = (rx_byte_i != sum_q);
    if (accept) begin
      unique case (phase_q)
        PhHeadLo: begin
          if (rx_byte_i == frame_header_i[7:0]) begin
            phase_d = PhHeadHi;
          end
        end
        PhHeadHi: begin
          // A repeated low header byte keeps the hunt one step in.
          priority if (rx_byte_i == frame_header_i[15:8]) begin
            phase_d = PhCmdLo;
          end else if (rx_byte_i == frame_header_i[7:0]) begin
            phase_d = PhHeadHi;
          end else begin
            phase_d = PhHeadLo;
          end
        end
        PhCmdLo: begin
          lo_d    = rx_byte_i;
          phase_d = PhCmdHi;
        end
        PhCmdHi: begin
          cmd_d   = {rx_byte_i, lo_q};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          lo_d    = rx_byte_i;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d   = new_len;
          seen_d  = '0;
          sum_d   = '0;
          phase_d = (new_len == '0) ? PhSum : PhData;
        end
        PhData: begin
          push_o  = 1'b1;
          sum_d   = sum_q + rx_byte_i;
          seen_d  = seen_next[cfd_pkg::WordW-1:0];
          if (seen_next >= {1'b0, len_q}) begin
            phase_d = PhSum;
          end
        end
        PhSum: begin
          push_o      = 1'b1;
          item_o.kind = cfd_pkg::KindEnd;
          phase_d     = PhHeadLo;
        end
        default: begin
          phase_d = PhHeadLo;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeadLo;
      cmd_q   <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
      lo_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      lo_q    <= lo_d;
    end
  end

endmodule

### hw/rtl/cfd_queue.sv
module cfd_queue #(
  parameter int unsigned Depth = cfd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfd_pkg::item_t item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output cfd_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cfd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/cfd_back.sv
module cfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  cfd_pkg::item_t item_i,
  output logic           pop_o,
  cfd_res_if.source      res_o
);

  logic                          valid_q;
  logic                          load;
  logic                          is_end;
  logic [cfd_pkg::StatusW-1:0]   status;

  assign load   = pop_valid_i && (!valid_q || res_o.ready);
  assign pop_o  = load;
  assign is_end = (item_i.kind == cfd_pkg::KindEnd);

  // A checksum mismatch outranks an unknown command.
  always_comb begin
    priority if (!is_end) begin
      status = cfd_pkg::StatusGood;
    end else if (item_i.sum_bad) begin
      status = cfd_pkg::StatusSumError;
    end else if (!cfd_pkg::is_known_cmd(item_i.command)) begin
      status = cfd_pkg::StatusUnknown;
    end else begin
      status = cfd_pkg::StatusGood;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_o.result_kind  <= is_end;
      res_o.payload_byte <= is_end ? '0 : item_i.data;
      res_o.byte_index   <= is_end ? '0 : item_i.index;
      res_o.command      <= item_i.command;
      res_o.frame_status <= status;
      res_o.last         <= is_end;
    end
  end

  assign res_o.valid = valid_q;

endmodule
